FILE: rtl/positional_list_engine_unit_defines.svh
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Concurrent assertion helpers that are empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PLE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define PLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PLE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define PLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Command codes, status codes and value limits shared by the engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

    localparam int DefCapacity = 64;
    localparam int ValueW      = 16;
    localparam int ElemW       = 15;
    localparam int PosW        = 7;

    typedef logic [2:0] func_t;
    typedef logic [2:0] status_t;

    localparam func_t FUNC_INS_END   = 3'd0;
    localparam func_t FUNC_INS_FRONT = 3'd1;
    localparam func_t FUNC_INS_AT    = 3'd2;
    localparam func_t FUNC_READOUT   = 3'd3;
    localparam func_t FUNC_UPDATE    = 3'd4;
    localparam func_t FUNC_DEL_FIRST = 3'd5;
    localparam func_t FUNC_DEL_LAST  = 3'd6;
    localparam func_t FUNC_DEL_AT    = 3'd7;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_BAD_VALUE = 3'd1;
    localparam status_t ST_BAD_POS   = 3'd2;
    localparam status_t ST_EMPTY     = 3'd3;
    localparam status_t ST_FULL      = 3'd4;
    localparam status_t ST_ELEMENT   = 3'd5;

    localparam logic signed [ValueW-1:0] VAL_MIN = -16'sd10000;
    localparam logic signed [ValueW-1:0] VAL_MAX = 16'sd10000;

endpackage

`default_nettype wire

FILE: rtl/positional_list_engine_unit.sv
// ----------------------------------------------------------------------------
// Positional list engine
// Bounded ordered list of signed values held in one RAM.
//
// The s_ channel takes one command per transfer (func, position, value). The
// m_ channel returns one status transfer per command, or for a read-out one
// transfer per entry with m_last on the final one (one empty transfer if the
// list is empty). Commands are worked one at a time; s_ready is high only
// while the engine is idle. Update and error answers move no entries and
// go straight to the response. An insert moves every entry behind the target
// up by one slot and a delete moves every entry behind it down, each move a
// RAM read and a RAM write. Read-out reads each entry from the RAM before
// sending it. The single RAM port pair paces this work. A stalled m_ channel
// holds its result register and the engine waits; an idle engine still takes
// a new command while a result waits. Reset empties the list; the RAM needs
// no clearing because only entries below the list length are read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "positional_list_engine_unit_defines.svh"

module positional_list_engine_unit #(
    parameter int CAPACITY = ple_pkg::DefCapacity
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [2:0]                         s_func,
    input  wire logic [ple_pkg::PosW-1:0]           s_position,
    input  wire logic signed [ple_pkg::ValueW-1:0]  s_value,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [2:0]                              m_status,
    output logic signed [ple_pkg::ElemW-1:0]        m_value_res,
    output logic                                    m_last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = 8;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INSC = 3'd1;
    localparam logic [2:0] S_INSW = 3'd2;
    localparam logic [2:0] S_DELC = 3'd3;
    localparam logic [2:0] S_DELW = 3'd4;
    localparam logic [2:0] S_ORD  = 3'd5;
    localparam logic [2:0] S_ODT  = 3'd6;
    localparam logic [2:0] S_RESP = 3'd7;

    logic [2:0]                    state_reg, state_next;
    logic [LW-1:0]                 len_reg, len_next;
    logic [LW-1:0]                 cnt_reg, cnt_next;
    logic [LW-1:0]                 idx_reg, idx_next;
    logic [ple_pkg::ElemW-1:0]     val_reg, val_next;
    ple_pkg::status_t              st_reg, st_next;

    logic                          m_valid_reg, m_valid_next;
    ple_pkg::status_t              m_status_reg, m_status_next;
    logic [ple_pkg::ElemW-1:0]     m_value_reg, m_value_next;
    logic                          m_last_reg, m_last_next;

    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [ple_pkg::ElemW-1:0]     wr_data;
    logic [AW-1:0]                 rd_addr;
    logic [ple_pkg::ElemW-1:0]     rd_data;

    logic                          accept;
    logic                          out_free;
    logic                          val_ok;
    logic                          is_full;
    logic                          is_empty;
    logic [CW-1:0]                 posx;
    logic [CW-1:0]                 lenx;
    logic                          pos_ins_bad;
    logic                          pos_bad;
    logic [LW-1:0]                 pos_idx;

    assign s_ready     = (state_reg == S_IDLE);
    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign val_ok      = (s_value >= ple_pkg::VAL_MIN) && (s_value <= ple_pkg::VAL_MAX);
    assign is_full     = (len_reg == LW'(CAPACITY));
    assign is_empty    = (len_reg == '0);
    assign posx        = CW'(s_position);
    assign lenx        = CW'(len_reg);
    assign pos_ins_bad = (posx == '0) || (posx > lenx + CW'(1));
    assign pos_bad     = (posx == '0) || is_empty || (posx > lenx);
    assign pos_idx     = LW'(s_position - ple_pkg::PosW'(1));

    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        st_next       = st_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_last_next   = m_last_reg;
        wr_en         = 1'b0;
        wr_addr       = cnt_reg[AW-1:0];
        wr_data       = rd_data;
        rd_addr       = cnt_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    val_next   = s_value[ple_pkg::ElemW-1:0];
                    st_next    = ple_pkg::ST_OK;
                    state_next = S_RESP;
                    case (s_func)
                        ple_pkg::FUNC_INS_END, ple_pkg::FUNC_INS_FRONT: begin
                            if (!val_ok) begin
                                st_next = ple_pkg::ST_BAD_VALUE;
                            end else if (is_full) begin
                                st_next = ple_pkg::ST_FULL;
                            end else begin
                                idx_next   = (s_func == ple_pkg::FUNC_INS_END) ? len_reg : '0;
                                cnt_next   = len_reg;
                                state_next = S_INSC;
                            end
                        end
                        ple_pkg::FUNC_INS_AT: begin
                            if (!val_ok) begin
                                st_next = ple_pkg::ST_BAD_VALUE;
                            end else if (pos_ins_bad) begin
                                st_next = ple_pkg::ST_BAD_POS;
                            end else if (is_full) begin
                                st_next = ple_pkg::ST_FULL;
                            end else begin
                                idx_next   = pos_idx;
                                cnt_next   = len_reg;
                                state_next = S_INSC;
                            end
                        end
                        ple_pkg::FUNC_READOUT: begin
                            if (is_empty) begin
                                st_next = ple_pkg::ST_EMPTY;
                            end else begin
                                cnt_next   = '0;
                                state_next = S_ORD;
                            end
                        end
                        ple_pkg::FUNC_UPDATE: begin
                            if (!val_ok) begin
                                st_next = ple_pkg::ST_BAD_VALUE;
                            end else if (pos_bad) begin
                                st_next = ple_pkg::ST_BAD_POS;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = pos_idx[AW-1:0];
                                wr_data = s_value[ple_pkg::ElemW-1:0];
                            end
                        end
                        ple_pkg::FUNC_DEL_FIRST, ple_pkg::FUNC_DEL_LAST: begin
                            if (is_empty) begin
                                st_next = ple_pkg::ST_EMPTY;
                            end else begin
                                cnt_next   = (s_func == ple_pkg::FUNC_DEL_FIRST) ?
                                             '0 : len_reg - LW'(1);
                                state_next = S_DELC;
                            end
                        end
                        default: begin
                            if (pos_bad) begin
                                st_next = ple_pkg::ST_BAD_POS;
                            end else begin
                                cnt_next   = pos_idx;
                                state_next = S_DELC;
                            end
                        end
                    endcase
                end
            end
            S_INSC: begin
                if (cnt_reg > idx_reg) begin
                    rd_addr    = AW'(cnt_reg - LW'(1));
                    state_next = S_INSW;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = idx_reg[AW-1:0];
                    wr_data    = val_reg;
                    len_next   = len_reg + LW'(1);
                    state_next = S_RESP;
                end
            end
            S_INSW: begin
                wr_en      = 1'b1;
                cnt_next   = cnt_reg - LW'(1);
                state_next = S_INSC;
            end
            S_DELC: begin
                if (cnt_reg + LW'(1) < len_reg) begin
                    rd_addr    = AW'(cnt_reg + LW'(1));
                    state_next = S_DELW;
                end else begin
                    len_next   = len_reg - LW'(1);
                    state_next = S_RESP;
                end
            end
            S_DELW: begin
                wr_en      = 1'b1;
                cnt_next   = cnt_reg + LW'(1);
                state_next = S_DELC;
            end
            S_ORD: begin
                if (out_free) begin
                    state_next = S_ODT;
                end
            end
            S_ODT: begin
                m_valid_next  = 1'b1;
                m_status_next = ple_pkg::ST_ELEMENT;
                m_value_next  = rd_data;
                m_last_next   = (cnt_reg + LW'(1) == len_reg);
                cnt_next      = cnt_reg + LW'(1);
                state_next    = (cnt_reg + LW'(1) == len_reg) ? S_IDLE : S_ORD;
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = st_reg;
                    m_value_next  = '0;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
        end
        cnt_reg      <= cnt_next;
        idx_reg      <= idx_next;
        val_reg      <= val_next;
        st_reg       <= st_next;
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_last_reg   <= m_last_next;
    end

    ple_ram #(
        .Width (ple_pkg::ElemW),
        .Depth (CAPACITY),
        .AddrW (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_value_res = m_value_reg;
    assign m_last      = m_last_reg;

    `PLE_ASSERT_IMPL(a_len_bound, aclk, aresetn, 1'b1, len_reg <= LW'(CAPACITY), "length over capacity")
    `PLE_ASSERT_NEXT(a_len_step, aclk, aresetn, 1'b1, (len_reg == $past(len_reg)) || (len_reg == $past(len_reg) + LW'(1)) || (len_reg + LW'(1) == $past(len_reg)), "length moved by more than one")
    `PLE_ASSERT_IMPL(a_odt_free, aclk, aresetn, state_reg == S_ODT, !m_valid_reg, "read-out result overwrote a pending transfer")
    `PLE_ASSERT_IMPL(a_wr_range, aclk, aresetn, wr_en, {1'b0, wr_addr} < (AW + 1)'(CAPACITY), "RAM write outside the store")

endmodule

`default_nettype wire

FILE: rtl/ple_ram.sv
// ----------------------------------------------------------------------------
// Positional list engine RAM
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ram #(
    parameter int Width = 15,
    parameter int Depth = 64,
    parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AddrW-1:0] wr_addr,
    input  wire logic [Width-1:0] wr_data,
    input  wire logic [AddrW-1:0] rd_addr,
    output logic      [Width-1:0] rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire
